FILE: hdl/qtbd_pkg.sv
// Shared constants and types for the quote tick binary decoder.
`timescale 1ns / 1ps
`default_nettype none
package qtbd_pkg;
  localparam int HDR_BYTES = 108;
  localparam int MAX_SYMBOL_BYTES_DEF = 64;
  localparam logic [31:0] TICK_MAGIC = 32'h5451_544D;
  localparam logic [15:0] PROTO_VERSION = 16'd1;
  localparam int NUM_FIELDS = 14;

  typedef enum logic [1:0] {
    KIND_SYMBOL = 2'd0,
    KIND_FIELD  = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_SHORT    = 4'd1,
    ST_HEADER   = 4'd2,
    ST_LENGTH   = 4'd3,
    ST_PLATFORM = 4'd4,
    ST_SOURCE   = 4'd5,
    ST_UTF8     = 4'd6,
    ST_BIDASK   = 4'd7,
    ST_LAST     = 4'd8,
    ST_TIME     = 4'd9
  } status_t;

  typedef enum logic [1:0] {
    PH_RUN,
    PH_EVAL,
    PH_EMIT
  } phase_t;

  // UTF-8 checker control from the top level
  typedef struct packed {
    logic feed;
    logic clear;
  } utf8_ctl_t;
endpackage
`default_nettype wire

FILE: hdl/qtbd_utf8.sv
// Strict UTF-8 validator for the symbol bytes.
`timescale 1ns / 1ps
`default_nettype none
module qtbd_utf8
  import qtbd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire utf8_ctl_t  ctl,
  input  wire logic [7:0] data_byte,
  output logic            fail_nxt
);
  logic [1:0] pend_r, pend_nxt;
  logic [2:0] cls_r, cls_nxt;
  logic       err_r, err_nxt;
  logic [7:0] lo, hi;

  always_comb begin
    pend_nxt = pend_r;
    cls_nxt  = cls_r;
    err_nxt  = err_r;
    lo = 8'h80;
    hi = 8'hBF;
    unique case (cls_r)
      3'd1: lo = 8'hA0;
      3'd2: hi = 8'h9F;
      3'd3: lo = 8'h90;
      3'd4: hi = 8'h8F;
      default: ;
    endcase
    if (ctl.feed && !err_r) begin
      if (pend_r != 2'd0) begin
        if (data_byte < lo || data_byte > hi) begin
          err_nxt = 1'b1;
        end else begin
          cls_nxt  = 3'd0;
          pend_nxt = pend_r - 2'd1;
        end
      end else if (data_byte <= 8'h7F) begin
        if (data_byte < 8'h20 || data_byte == 8'h7F) err_nxt = 1'b1;
      end else if (data_byte >= 8'hC2 && data_byte <= 8'hDF) begin
        pend_nxt = 2'd1;
        cls_nxt  = 3'd0;
      end else if (data_byte >= 8'hE0 && data_byte <= 8'hEF) begin
        pend_nxt = 2'd2;
        cls_nxt  = (data_byte == 8'hE0) ? 3'd1 : (data_byte == 8'hED) ? 3'd2 : 3'd0;
      end else if (data_byte >= 8'hF0 && data_byte <= 8'hF4) begin
        pend_nxt = 2'd3;
        cls_nxt  = (data_byte == 8'hF0) ? 3'd3 : (data_byte == 8'hF4) ? 3'd4 : 3'd0;
      end else begin
        err_nxt = 1'b1;
      end
    end
    fail_nxt = err_nxt || (pend_nxt != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      pend_r <= '0;
      cls_r  <= '0;
      err_r  <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      cls_r  <= cls_nxt;
      err_r  <= err_nxt;
    end
  end
endmodule
`default_nettype wire

FILE: hdl/quote_tick_binary_decoder_core.sv
// Top level of the quote tick binary decoder: byte capture, checks and record output.
// A symbol byte is registered and appears on the output in the cycle after it is accepted.
// Throughput: one payload byte per cycle while the output is taken.
// After the end byte: evaluation, then up to fifteen sequencer records one per cycle
// while the output takes them; input is held off until the status record is loaded.
// Reset: counter, UTF-8 state, sequencer and output valid clear; header bytes do not.
`timescale 1ns / 1ps
`default_nettype none
module quote_tick_binary_decoder_core
  import qtbd_pkg::*;
#(
  parameter int MAX_SYMBOL_BYTES = MAX_SYMBOL_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // data_byte
  input  wire logic        in_tlast,   // end_of_payload
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata,  // field_index[3:0], field_value[67:4],
                                       // status_code[71:68], symbol_length[78:72]
  output logic [1:0]       out_tuser,  // record_kind
  output logic             out_tlast   // run_last
);
  localparam int CAP = HDR_BYTES + MAX_SYMBOL_BYTES + 1;
  localparam int CW  = $clog2(CAP + 1);
  localparam logic [CW-1:0] CAP_C  = CW'(CAP);
  localparam logic [CW-1:0] HDR_C  = CW'(HDR_BYTES);
  localparam logic [CW-1:0] SYMEND = CW'(HDR_BYTES + MAX_SYMBOL_BYTES);

  logic [7:0]      hdr_r [HDR_BYTES];
  logic [HDR_BYTES*8-1:0] hf;
  logic [CW-1:0]   cnt_r, cnt_nxt, total;
  logic [CW-1:0]   tot_r;
  logic            u8bad_r;
  phase_t          ph_r, ph_nxt;
  logic [3:0]      idx_r, idx_nxt;
  status_t         st_r, st_c;
  logic [6:0]      slen_r, slen_c;
  logic [73:0]     prod_r, tdiff;
  utf8_ctl_t       uctl;
  logic            fail_nxt;

  logic            ov_r, ov_nxt;
  kind_t           okind_r, okind_nxt;
  logic [3:0]      oidx_r, oidx_nxt;
  logic [63:0]     oval_r, oval_nxt;
  status_t         ost_r, ost_nxt;
  logic [6:0]      oslen_r, oslen_nxt;
  logic            olast_r, olast_nxt;
  logic            out_free, acc;

  assign out_free  = !ov_r || out_tready;
  assign in_tready = (ph_r == PH_RUN) && out_free;
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    for (int i = 0; i < HDR_BYTES; i++) hf[i*8 +: 8] = hdr_r[i];
  end

  logic [31:0] f_magic, f_src, f_symlen;
  logic [15:0] f_ver, f_hsz, f_plat, f_resv;
  logic [63:0] f_ep, f_seq, f_t0, f_t1, f_t2, f_bid, f_ask, f_lst;
  logic [63:0] fld [NUM_FIELDS];
  assign f_magic  = hf[31:0];
  assign f_ver    = hf[47:32];
  assign f_hsz    = hf[63:48];
  assign f_plat   = hf[79:64];
  assign f_resv   = hf[95:80];
  assign f_src    = hf[127:96];
  assign f_ep     = hf[191:128];
  assign f_seq    = hf[255:192];
  assign f_symlen = hf[287:256];
  assign f_t0     = hf[415:352];
  assign f_t1     = hf[479:416];
  assign f_t2     = hf[543:480];
  assign f_bid    = hf[607:544];
  assign f_ask    = hf[671:608];
  assign f_lst    = hf[735:672];
  assign fld[0]  = {48'd0, f_ver};
  assign fld[1]  = {48'd0, f_plat};
  assign fld[2]  = {{32{f_src[31]}}, f_src};
  assign fld[3]  = f_ep;
  assign fld[4]  = f_seq;
  assign fld[5]  = hf[351:288];
  assign fld[6]  = f_t0;
  assign fld[7]  = f_t1;
  assign fld[8]  = f_t2;
  assign fld[9]  = f_bid;
  assign fld[10] = f_ask;
  assign fld[11] = f_lst;
  assign fld[12] = hf[799:736];
  assign fld[13] = hf[863:800];

  assign total = (cnt_r == CAP_C) ? CAP_C : cnt_r + CW'(1);
  assign uctl.feed  = acc && cnt_r >= HDR_C && cnt_r < SYMEND;
  assign uctl.clear = acc && in_tlast;

  qtbd_utf8 u_utf8 (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (uctl),
    .data_byte(in_tdata),
    .fail_nxt (fail_nxt)
  );

  // t1 / 1000 == t0 exactly when t1 - 1000*t0 lies in 0..999
  assign tdiff = {10'd0, f_t1} - prod_r;

  function automatic logic price_ok(input logic [63:0] b);
    price_ok = (b[62:52] != 11'h7FF) && !b[63] && (b[62:0] != 63'd0);
  endfunction

  always_comb begin
    logic [31:0] body;
    body = 32'(tot_r) - 32'(HDR_BYTES);
    slen_c = (f_symlen > 32'(MAX_SYMBOL_BYTES)) ? 7'(MAX_SYMBOL_BYTES) : f_symlen[6:0];
    st_c = ST_OK;
    if (tot_r < HDR_C) begin
      st_c   = ST_SHORT;
      slen_c = 7'd0;
    end else if (f_magic != TICK_MAGIC || f_ver != PROTO_VERSION ||
                 f_hsz != 16'(HDR_BYTES) || f_resv != 16'd0) begin
      st_c = ST_HEADER;
    end else if (f_symlen == 32'd0 || f_symlen > 32'(MAX_SYMBOL_BYTES) ||
                 body != f_symlen) begin
      st_c = ST_LENGTH;
    end else if (f_plat != 16'd4 && f_plat != 16'd5) begin
      st_c = ST_PLATFORM;
    end else if (f_src == 32'd0 || f_src[31] || f_ep == 64'd0 || f_seq == 64'd0) begin
      st_c = ST_SOURCE;
    end else if (u8bad_r) begin
      st_c = ST_UTF8;
    end else if (!price_ok(f_bid) || !price_ok(f_ask)) begin
      st_c = ST_BIDASK;
    end else if (f_lst[62:52] == 11'h7FF || (f_lst[63] && f_lst[62:0] != 63'd0)) begin
      st_c = ST_LAST;
    end else if (f_t0[63] || f_t0 == 64'd0 || f_t1[63] || f_t1 == 64'd0 ||
                 f_t2[63] || f_t2 == 64'd0 || !(tdiff < 74'd1000)) begin
      st_c = ST_TIME;
    end
  end

  always_comb begin
    ph_nxt    = ph_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = ov_r && !out_tready;
    okind_nxt = okind_r;
    oidx_nxt  = oidx_r;
    oval_nxt  = oval_r;
    ost_nxt   = ost_r;
    oslen_nxt = oslen_r;
    olast_nxt = olast_r;
    unique case (ph_r)
      PH_RUN: begin
        if (acc) begin
          cnt_nxt = total;
          if (uctl.feed) begin
            ov_nxt    = 1'b1;
            okind_nxt = KIND_SYMBOL;
            oidx_nxt  = 4'd0;
            oval_nxt  = {56'd0, in_tdata};
            ost_nxt   = ST_OK;
            oslen_nxt = 7'd0;
            olast_nxt = 1'b0;
          end
          if (in_tlast) begin
            cnt_nxt = '0;
            ph_nxt  = PH_EVAL;
          end
        end
      end
      PH_EVAL: begin
        ph_nxt  = PH_EMIT;
        idx_nxt = (st_c == ST_OK) ? 4'd0 : 4'(NUM_FIELDS);
      end
      PH_EMIT: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          if (idx_r == 4'(NUM_FIELDS)) begin
            okind_nxt = KIND_STATUS;
            oidx_nxt  = 4'd0;
            oval_nxt  = 64'd0;
            ost_nxt   = st_r;
            oslen_nxt = slen_r;
            olast_nxt = 1'b1;
            ph_nxt    = PH_RUN;
          end else begin
            okind_nxt = KIND_FIELD;
            oidx_nxt  = idx_r;
            oval_nxt  = fld[idx_r];
            ost_nxt   = ST_OK;
            oslen_nxt = 7'd0;
            olast_nxt = 1'b0;
            idx_nxt   = idx_r + 4'd1;
          end
        end
      end
      default: ph_nxt = PH_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= PH_RUN;
      cnt_r <= '0;
      ov_r  <= 1'b0;
      idx_r <= '0;
    end else begin
      ph_r  <= ph_nxt;
      cnt_r <= cnt_nxt;
      ov_r  <= ov_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && cnt_r < HDR_C) hdr_r[cnt_r[$clog2(HDR_BYTES)-1:0]] <= in_tdata;
    if (acc && in_tlast) begin
      tot_r   <= total;
      u8bad_r <= fail_nxt;
    end
    prod_r <= {10'd0, f_t0} * 74'd1000;
    if (ph_r == PH_EVAL) begin
      st_r   <= st_c;
      slen_r <= slen_c;
    end
    okind_r <= okind_nxt;
    oidx_r  <= oidx_nxt;
    oval_r  <= oval_nxt;
    ost_r   <= ost_nxt;
    oslen_r <= oslen_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {1'b0, oslen_r, ost_r, oval_r, oidx_r};
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;
endmodule
`default_nettype wire

FILE: tb/sv/quote_tick_binary_decoder_core_chk.sv
// Checker for the quote tick decoder: predicts records per accepted byte and compares outputs.
`timescale 1ns / 1ps
module quote_tick_binary_decoder_core_chk
  import qtbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [79:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending_count,
  output int          status_seen,
  output int          ok_seen
);
  localparam int SYM_MAX = MAX_SYMBOL_BYTES_DEF;
  localparam int COUNT_CAP = HDR_BYTES + SYM_MAX + 1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  index;
    logic [63:0] value;
    logic [3:0]  status;
    logic [6:0]  slen;
    logic        last;
  } record_t;

  record_t   expected_records[$];
  logic [7:0] hdr_bytes [HDR_BYTES];
  int        byte_pos;
  int        u_pend;
  int        u_class;
  bit        u_err;

  function automatic logic [63:0] hdr_field(int off, int n);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < n; i++) v[8*i +: 8] = hdr_bytes[off + i];
    return v;
  endfunction

  function automatic bit is_finite(logic [63:0] b);
    return b[62:52] != 11'h7FF;
  endfunction

  task automatic utf8_step(int b);
    int lo, hi;
    if (u_err) return;
    if (u_pend != 0) begin
      lo = 'h80; hi = 'hBF;
      case (u_class)
        1: lo = 'hA0;
        2: hi = 'h9F;
        3: lo = 'h90;
        4: hi = 'h8F;
        default: ;
      endcase
      if (b < lo || b > hi) begin
        u_err = 1;
        return;
      end
      u_class = 0;
      u_pend--;
      return;
    end
    if (b <= 'h7F) begin
      if (b < 'h20 || b == 'h7F) u_err = 1;
    end else if (b >= 'hC2 && b <= 'hDF) begin
      u_pend = 1; u_class = 0;
    end else if (b >= 'hE0 && b <= 'hEF) begin
      u_pend = 2; u_class = (b == 'hE0) ? 1 : (b == 'hED) ? 2 : 0;
    end else if (b >= 'hF0 && b <= 'hF4) begin
      u_pend = 3; u_class = (b == 'hF0) ? 3 : (b == 'hF4) ? 4 : 0;
    end else begin
      u_err = 1;
    end
  endtask

  function automatic record_t mk(kind_t k, int idx, logic [63:0] v, status_t s, int sl,
                                 bit l);
    record_t r;
    r.kind = k; r.index = idx[3:0]; r.value = v; r.status = s; r.slen = sl[6:0];
    r.last = l;
    return r;
  endfunction

  task automatic queue_record(record_t r);
    expected_records = {expected_records, r};
  endtask

  task automatic predict_byte(logic [7:0] b, logic endp);
    int total, sl;
    status_t st;
    logic [63:0] fv [NUM_FIELDS];
    logic [63:0] magic, ver, hsz, plat, resv, src, src_raw, symlen;
    st = ST_OK;
    sl = 0;
    if (byte_pos < HDR_BYTES) begin
      hdr_bytes[byte_pos] = b;
    end else if (byte_pos < HDR_BYTES + SYM_MAX) begin
      queue_record(mk(KIND_SYMBOL, 0, {56'd0, b}, ST_OK, 0, 0));
      utf8_step(b);
    end
    total = byte_pos + 1;
    if (total > COUNT_CAP) total = COUNT_CAP;
    if (!endp) begin
      byte_pos = total;
      return;
    end
    if (total < HDR_BYTES) begin
      st = ST_SHORT;
    end else begin
      magic = hdr_field(0, 4); ver = hdr_field(4, 2); hsz = hdr_field(6, 2);
      plat = hdr_field(8, 2); resv = hdr_field(10, 2);
      src_raw = hdr_field(12, 4);
      src = {{32{src_raw[31]}}, src_raw[31:0]};
      symlen = hdr_field(32, 4);
      sl = (symlen > SYM_MAX) ? SYM_MAX : int'(symlen);
      fv[0] = ver; fv[1] = plat; fv[2] = src;
      fv[3] = hdr_field(16, 8); fv[4] = hdr_field(24, 8); fv[5] = hdr_field(36, 8);
      for (int i = 6; i < NUM_FIELDS; i++) fv[i] = hdr_field(44 + 8 * (i - 6), 8);
      if (magic != TICK_MAGIC || ver != PROTO_VERSION || hsz != HDR_BYTES || resv != 0)
        st = ST_HEADER;
      else if (symlen == 0 || symlen > SYM_MAX || (total - HDR_BYTES) != symlen)
        st = ST_LENGTH;
      else if (plat != 4 && plat != 5)
        st = ST_PLATFORM;
      else if (src == 0 || src[63] || fv[3] == 0 || fv[4] == 0)
        st = ST_SOURCE;
      else if (u_err || u_pend != 0)
        st = ST_UTF8;
      else if (!is_finite(fv[9]) || !is_finite(fv[10]) || fv[9][63] || fv[10][63] ||
               fv[9] == 0 || fv[10] == 0)
        st = ST_BIDASK;
      else if (!is_finite(fv[11]) || (fv[11][63] && fv[11][62:0] != 0))
        st = ST_LAST;
      else if (fv[6][63] || fv[6] == 0 || fv[7][63] || fv[7] == 0 ||
               fv[8][63] || fv[8] == 0 || fv[7] / 64'd1000 != fv[6])
        st = ST_TIME;
      if (st == ST_OK)
        for (int i = 0; i < NUM_FIELDS; i++)
          queue_record(mk(KIND_FIELD, i, fv[i], ST_OK, 0, 0));
    end
    queue_record(mk(KIND_STATUS, 0, 64'd0, st, sl, 1));
    byte_pos = 0; u_pend = 0; u_class = 0; u_err = 0;
  endtask

  assign pending_count = expected_records.size();

  always @(posedge clk) begin
    record_t got, want;
    if (!rst_n) begin
      byte_pos <= 0; u_pend <= 0; u_class <= 0; u_err <= 0;
      fail_count <= 0; status_seen <= 0; ok_seen <= 0;
    end else begin
      // compare first so a same-edge prediction cannot be mistaken for an older one
      if (out_tvalid && out_tready) begin
        got = mk(kind_t'(out_tuser), out_tdata[3:0], out_tdata[67:4],
                 status_t'(out_tdata[71:68]), out_tdata[78:72], out_tlast);
        if (expected_records.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected record %h", got);
        end else begin
          want = expected_records.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("exp/got k %0d/%0d i %0d/%0d v %h/%h s %0d/%0d n %0d/%0d l %0d/%0d",
                       want.kind, got.kind, want.index, got.index, want.value, got.value,
                       want.status, got.status, want.slen, got.slen, want.last, got.last);
          end
          if (want.kind == KIND_STATUS) begin
            status_seen <= status_seen + 1;
            if (want.status == ST_OK) ok_seen <= ok_seen + 1;
          end
        end
      end
      if (in_tvalid && in_tready) predict_byte(in_tdata, in_tlast);
    end
  end
endmodule

FILE: tb/sv/quote_tick_binary_decoder_core_tb.sv
// Testbench top for the quote tick decoder: payload stimulus, flow control and verdict.
`timescale 1ns / 1ps
module quote_tick_binary_decoder_core_tb;
  import qtbd_pkg::*;

  localparam int SYM_MAX = MAX_SYMBOL_BYTES_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS = 430;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [7:0]  in_tdata = 0;
  logic        in_tlast = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [79:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  int          fail_count, pending_count, status_seen, ok_seen;
  int          cycles = 0;
  int          items_sent = 0;
  int          burst_left = 0;

  // fault selector for generated payloads
  typedef enum int {
    FLT_NONE, FLT_MAGIC, FLT_VERSION, FLT_HSIZE, FLT_RESV, FLT_LEN_ZERO, FLT_LEN_BIG,
    FLT_LEN_MISMATCH, FLT_PLATFORM, FLT_SOURCE, FLT_EPOCH, FLT_SEQ, FLT_UTF8,
    FLT_BID, FLT_ASK, FLT_LAST, FLT_TIME, FLT_OVERLONG, FLT_SHORT, FLT_NOISE
  } fault_t;

  logic [7:0] payload [$];

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  quote_tick_binary_decoder_core dut (.*);

  quote_tick_binary_decoder_core_chk chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // receiver: alternating stall patterns, including stretches of always-ready
  always @(negedge clk) begin
    int phase;
    phase = (cycles / 500) % 4;
    case (phase)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= ((cycles % 7) < 4);
      default: out_tready <= ($urandom_range(0, 1) != 0);
    endcase
  end

  task automatic add_byte(logic [7:0] b);
    payload = {payload, b};
  endtask

  task automatic put_le(int off, logic [63:0] v, int n);
    for (int i = 0; i < n; i++) payload[off + i] = v[8*i +: 8];
  endtask

  function automatic logic [7:0] utf8_char_byte();
    return 8'($urandom_range('h20, 'h7E));
  endfunction

  // random valid UTF-8 symbol of exactly n bytes
  task automatic valid_symbol(int n);
    int left, c;
    left = n;
    while (left > 0) begin
      c = $urandom_range(1, (left < 4) ? left : 4);
      case (c)
        1: add_byte(utf8_char_byte());
        2: begin
          add_byte(8'($urandom_range('hC2, 'hDF)));
          add_byte(8'($urandom_range('h80, 'hBF)));
        end
        3: begin
          case ($urandom_range(0, 2))
            0: begin
              add_byte(8'hE0);
              add_byte(8'($urandom_range('hA0, 'hBF)));
            end
            1: begin
              add_byte(8'hED);
              add_byte(8'($urandom_range('h80, 'h9F)));
            end
            default: begin
              add_byte(8'($urandom_range('hE1, 'hEF)));
              add_byte(8'($urandom_range('h80, 'hBF)));
            end
          endcase
          add_byte(8'($urandom_range('h80, 'hBF)));
        end
        default: begin
          case ($urandom_range(0, 2))
            0: begin
              add_byte(8'hF0);
              add_byte(8'($urandom_range('h90, 'hBF)));
            end
            1: begin
              add_byte(8'hF4);
              add_byte(8'($urandom_range('h80, 'h8F)));
            end
            default: begin
              add_byte(8'($urandom_range('hF1, 'hF3)));
              add_byte(8'($urandom_range('h80, 'hBF)));
            end
          endcase
          add_byte(8'($urandom_range('h80, 'hBF)));
          add_byte(8'($urandom_range('h80, 'hBF)));
        end
      endcase
      left -= c;
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pos_double();
    logic [63:0] d;
    d = rand64();
    d[63] = 0;
    if (d[62:52] == 11'h7FF) d[62] = 0;
    if (d == 0) d = 64'h3FF0_0000_0000_0000;
    return d;
  endfunction

  // build a payload around a fault; sym is the symbol length
  task automatic build_payload(fault_t f, int sym);
    logic [63:0] t0, t1;
    int decl;
    payload.delete();
    for (int i = 0; i < HDR_BYTES; i++) add_byte(8'h00);
    put_le(0, TICK_MAGIC, 4);
    put_le(4, PROTO_VERSION, 2);
    put_le(6, HDR_BYTES, 2);
    put_le(8, $urandom_range(4, 5), 2);
    put_le(12, {32'd0, 1'b0, 31'($urandom_range(1, 32'h7FFF_FFFF))}, 4);
    put_le(16, rand64() | 64'd1, 8);
    put_le(24, rand64() | 64'd2, 8);
    put_le(36, rand64(), 8);
    t0 = {1'b0, 22'd0, 41'(rand64())} + 1;
    t1 = t0 * 1000 + $urandom_range(0, 999);
    put_le(44, t0, 8);
    put_le(52, t1, 8);
    put_le(60, {1'b0, 63'(rand64())} | 64'd1, 8);
    put_le(68, pos_double(), 8);
    put_le(76, pos_double(), 8);
    put_le(84, ($urandom_range(0, 3) == 0) ? 64'h8000_0000_0000_0000 : pos_double(), 8);
    put_le(92, rand64(), 8);
    put_le(100, rand64(), 8);
    decl = sym;
    valid_symbol(sym);
    case (f)
      FLT_MAGIC:    payload[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
      FLT_VERSION:  put_le(4, $urandom_range(2, 65535), 2);
      FLT_HSIZE:    put_le(6, $urandom_range(0, 107), 2);
      FLT_RESV:     put_le(10, $urandom_range(1, 65535), 2);
      FLT_LEN_ZERO: decl = 0;
      FLT_LEN_BIG:  decl = ($urandom_range(0, 1)) ? SYM_MAX + 1 : $urandom();
      FLT_LEN_MISMATCH: decl = sym + 1;
      FLT_PLATFORM: put_le(8, ($urandom_range(0, 1)) ? $urandom_range(0, 3)
                                                      : $urandom_range(6, 65535), 2);
      FLT_SOURCE:   put_le(12, ($urandom_range(0, 1)) ? 0 : $urandom() | 32'h8000_0000, 4);
      FLT_EPOCH:    put_le(16, 0, 8);
      FLT_SEQ:      put_le(24, 0, 8);
      FLT_UTF8: begin
        case ($urandom_range(0, 6))
          0: payload[HDR_BYTES + $urandom_range(0, sym - 1)] = 8'($urandom_range(0, 'h1F));
          1: payload[HDR_BYTES + $urandom_range(0, sym - 1)] = 8'h7F;
          2: payload[HDR_BYTES + $urandom_range(0, sym - 1)] = 8'($urandom_range('hC0, 'hC1));
          3: payload[HDR_BYTES + $urandom_range(0, sym - 1)] = 8'($urandom_range('hF5, 'hFF));
          4: payload[$] = 8'($urandom_range('hC2, 'hF4));
          5: payload[HDR_BYTES + $urandom_range(0, sym - 1)] = 8'($urandom_range('h80, 'hBF));
          default: begin
            // surrogate or out-of-range continuation
            if (sym >= 3) begin
              payload[HDR_BYTES] = ($urandom_range(0, 1)) ? 8'hED : 8'hE0;
              payload[HDR_BYTES + 1] = (payload[HDR_BYTES] == 8'hED) ? 8'hA0 : 8'h9F;
            end else payload[HDR_BYTES] = 8'hFF;
          end
        endcase
      end
      FLT_BID, FLT_ASK: begin
        case ($urandom_range(0, 3))
          0: put_le((f == FLT_BID) ? 68 : 76, 0, 8);
          1: put_le((f == FLT_BID) ? 68 : 76, 64'h8000_0000_0000_0000, 8);
          2: put_le((f == FLT_BID) ? 68 : 76, pos_double() | 64'h8000_0000_0000_0000, 8);
          default: put_le((f == FLT_BID) ? 68 : 76, {1'b0, 11'h7FF, 52'(rand64())}, 8);
        endcase
      end
      FLT_LAST: put_le(84, ($urandom_range(0, 1)) ? pos_double() | 64'h8000_0000_0000_0000
                                                  : {rand64()} | 64'h7FF0_0000_0000_0000, 8);
      FLT_TIME: begin
        case ($urandom_range(0, 4))
          0: put_le(44, 0, 8);
          1: put_le(52, 64'h8000_0000_0000_0000 | rand64(), 8);
          2: put_le(60, 0, 8);
          3: put_le(60, 64'h8000_0000_0000_0000 | rand64(), 8);
          default: put_le(52, (t0 + 1) * 1000, 8);
        endcase
      end
      FLT_OVERLONG: for (int i = 0; i < $urandom_range(1, 20); i++)
                      add_byte(8'($urandom()));
      FLT_SHORT: while (payload.size() > $urandom_range(1, HDR_BYTES - 1))
                   void'(payload.pop_back());
      FLT_NOISE: for (int i = 0; i < payload.size(); i++) payload[i] = 8'($urandom());
      default: ;
    endcase
    // a truncated payload may no longer hold the length field
    if (payload.size() >= 36) put_le(32, decl, 4);
  endtask

  // send one payload as a stream of bursts and gaps
  task automatic send_payload();
    for (int i = 0; i < payload.size(); i++) begin
      if (burst_left == 0) begin
        in_tvalid <= 0;
        repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 6)) @(negedge clk);
        burst_left = $urandom_range(1, 40);
      end
      in_tvalid <= 1;
      in_tdata <= payload[i];
      in_tlast <= (i == payload.size() - 1);
      // ready is stable from just after the falling edge up to the rising edge
      #1;
      while (!in_tready) begin
        @(negedge clk);
        #1;
      end
      @(posedge clk);
      items_sent++;
      burst_left--;
      @(negedge clk);
    end
    in_tvalid <= 0;
    in_tlast <= 0;
  endtask

  initial begin
    fault_t f;
    int sym;
    repeat (6) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: one-byte payloads, shortest and longest well-formed symbols
    payload.delete(); add_byte(8'hFF); send_payload();
    payload.delete(); add_byte(8'h00); send_payload();
    build_payload(FLT_NONE, 1); send_payload();
    build_payload(FLT_NONE, SYM_MAX); send_payload();

    // random: mostly short symbols, some large; a minority well-formed, the rest faults or noise
    while (items_sent < ITEMS) begin
      sym = ($urandom_range(0, 9) == 0) ? $urandom_range(40, SYM_MAX) : $urandom_range(1, 6);
      f = ($urandom_range(0, 2) == 0) ? FLT_NONE : fault_t'($urandom_range(0, 19));
      build_payload(f, sym);
      // trim the closing payload so the run stays on its byte budget
      while (payload.size() > 1 && items_sent + payload.size() > ITEMS)
        void'(payload.pop_back());
      send_payload();
    end

    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("sent %0d bytes; %0d payloads checked, %0d decoded fully",
             items_sent, status_seen, ok_seen);
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

FILE: files.f
hdl/qtbd_pkg.sv
hdl/qtbd_utf8.sv
hdl/quote_tick_binary_decoder_core.sv
tb/sv/quote_tick_binary_decoder_core_chk.sv
tb/sv/quote_tick_binary_decoder_core_tb.sv
